// ----- sv/plv_pkg.sv -----
`default_nettype none

package plv_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 6;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_DELETE   = 2'd1,
        FN_TRAVERSE = 2'd2,
        FN_NOP      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_DATA   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_TRAV,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic signed [DATA_W-1:0]   entry_value;
        logic        [CNT_W-1:0]    entry_count;
        logic                       last;
    } res_t;

    typedef struct packed {
        logic [1:0] level;
        logic       pop;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- sv/plv_ofifo.sv -----
`default_nettype none

module plv_ofifo
    import plv_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire res_t                       push_word,
    output fifo_stat_t                      stat,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [2:0]                      status,
    output logic signed [DATA_W-1:0]        entry_value,
    output logic [CNT_W-1:0]                entry_count,
    output logic                            last
);

    res_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] level_reg;
    logic [1:0] level_next;
    logic       pop;
    res_t       head;

    assign out_valid = (level_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign head      = slot_reg[rd_ptr_reg];

    assign status      = head.status;
    assign entry_value = head.entry_value;
    assign entry_count = head.entry_count;
    assign last        = head.last;

    assign stat.level = level_reg;
    assign stat.pop   = pop;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ----- sv/plv_seq.sv -----
`default_nettype none

module plv_seq
    import plv_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 func,
    input  wire logic signed [DATA_W-1:0]   value,
    input  wire logic [POS_W-1:0]           position,
    input  wire fifo_stat_t                 fifo_stat,
    output logic                            push,
    output res_t                            push_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     rd_left_reg;
    logic [CW-1:0]     rd_left_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [AW-1:0]     wr_addr_reg;
    logic [AW-1:0]     wr_addr_next;
    logic              wr_pend_reg;
    logic              wr_pend_next;
    logic              trv_pend_reg;
    logic              trv_pend_next;
    logic              trv_last_reg;
    logic              trv_last_next;
    logic              ins_reg;
    logic              ins_next;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [AW-1:0]     vidx_reg;
    logic [AW-1:0]     vidx_next;
    status_t           status_reg;
    status_t           status_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;

    logic              accept;
    func_t             fn;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic              ins_full;
    logic              ins_bad;
    logic              del_empty;
    logic              del_bad;
    logic [CW-1:0]     moves_ins;
    logic [CW-1:0]     moves_del;
    logic [2:0]        lvl_after;
    logic              trv_issue;
    logic              resp_room;
    logic              rd_done;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign fn       = func_t'(func);

    assign pos_x     = XW'(position);
    assign cnt_x     = XW'(count_reg);
    assign ins_full  = (count_reg == CW'(DEPTH));
    assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
    assign del_empty = (count_reg == '0);
    assign del_bad   = (pos_x == '0) || (pos_x > cnt_x);
    assign moves_ins = CW'(cnt_x + XW'(1) - pos_x);
    assign moves_del = CW'(cnt_x - pos_x);

    assign lvl_after = 3'(fifo_stat.level) + 3'(trv_pend_reg) - 3'(fifo_stat.pop);
    assign trv_issue = (rd_left_reg != '0) && (lvl_after <= 3'd1);
    assign resp_room = (fifo_stat.level != 2'd2) || fifo_stat.pop;
    assign rd_done   = (rd_left_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (fn)
                        FN_INSERT:   state_next = (ins_full || ins_bad) ? S_RESP : S_SHIFT;
                        FN_DELETE:   state_next = (del_empty || del_bad) ? S_RESP : S_SHIFT;
                        FN_TRAVERSE: state_next = del_empty ? S_RESP : S_TRAV;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (rd_done)
                begin
                    state_next = ins_reg ? S_PUT : S_RESP;
                end
            end
            S_PUT:
            begin
                state_next = S_RESP;
            end
            S_TRAV:
            begin
                if (rd_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (resp_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        rd_left_next  = rd_left_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_addr_next  = wr_addr_reg;
        wr_pend_next  = 1'b0;
        trv_pend_next = 1'b0;
        trv_last_next = trv_last_reg;
        ins_next      = ins_reg;
        val_next      = val_reg;
        vidx_next     = vidx_reg;
        status_next   = status_reg;
        mem_re        = 1'b0;
        mem_we        = wr_pend_reg;
        mem_waddr     = wr_addr_reg;
        mem_wdata     = mem_rdata_reg;
        push          = 1'b0;
        push_word     = '{status: ST_DATA, entry_value: mem_rdata_reg,
                          entry_count: CNT_W'(count_reg), last: trv_last_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ins_next  = (fn == FN_INSERT);
                    val_next  = value;
                    vidx_next = AW'(position - POS_W'(1));
                    case (fn)
                        FN_INSERT:
                        begin
                            status_next  = ins_full ? ST_FULL : (ins_bad ? ST_BADPOS : ST_DONE);
                            rd_left_next = moves_ins;
                            rd_ptr_next  = AW'(count_reg - CW'(1));
                        end
                        FN_DELETE:
                        begin
                            status_next  = del_empty ? ST_EMPTY : (del_bad ? ST_BADPOS : ST_DONE);
                            rd_left_next = moves_del;
                            rd_ptr_next  = AW'(position);
                        end
                        FN_TRAVERSE:
                        begin
                            status_next  = del_empty ? ST_EMPTY : ST_DONE;
                            rd_left_next = count_reg;
                            rd_ptr_next  = '0;
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (!rd_done)
                begin
                    mem_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    rd_left_next = rd_left_reg - CW'(1);
                    if (ins_reg)
                    begin
                        rd_ptr_next  = rd_ptr_reg - AW'(1);
                        wr_addr_next = rd_ptr_reg + AW'(1);
                    end
                    else
                    begin
                        rd_ptr_next  = rd_ptr_reg + AW'(1);
                        wr_addr_next = rd_ptr_reg - AW'(1);
                    end
                end
                else if (!ins_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = vidx_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
            end
            S_TRAV:
            begin
                if (trv_issue)
                begin
                    mem_re        = 1'b1;
                    trv_pend_next = 1'b1;
                    trv_last_next = (rd_left_reg == CW'(1));
                    rd_left_next  = rd_left_reg - CW'(1);
                    rd_ptr_next   = rd_ptr_reg + AW'(1);
                end
            end
            S_RESP:
            begin
                if (resp_room)
                begin
                    push      = 1'b1;
                    push_word = '{status: status_reg, entry_value: '0,
                                  entry_count: CNT_W'(count_reg), last: 1'b1};
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase

        if (trv_pend_reg)
        begin
            push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_left_reg  <= '0;
            wr_pend_reg  <= 1'b0;
            trv_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_left_reg  <= rd_left_next;
            wr_pend_reg  <= wr_pend_next;
            trv_pend_reg <= trv_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg   <= rd_ptr_next;
        wr_addr_reg  <= wr_addr_next;
        trv_last_reg <= trv_last_next;
        ins_reg      <= ins_next;
        val_reg      <= val_next;
        vidx_reg     <= vidx_next;
        status_reg   <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire

// ----- sv/positional_insert_delete_list_unit.sv -----
// Ordered list of up to DEPTH signed 32-bit words with insert, delete and traverse.
// Input channel (in_valid/in_stall) carries func, value and position; a word is
// taken when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall) carries status, entry_value, entry_count and last.
// Insert, delete and the unused operation give one result word; traverse gives one data word per stored
// entry, last marking the final one, or a single empty word when the list is empty.
// Entries sit in a single-port-write, single-port-read RAM with a registered read
// port; shifts walk the RAM one entry per cycle, reading one word and writing
// back the word read in the previous cycle.
// Traverse streams one word per cycle while the receiver keeps out_stall low.
// A two-word output queue holds results, so the block takes its next input word
// while a result still waits; when out_stall stays high and the queue fills, the
// sequencer holds in its traverse or response step and in_stall stays high.
// Reset clears the entry count, the sequencer state, the pending flags and the output
// queue; the RAM is not cleared and needs no sweep, so the block is ready in the first cycle after reset.
`default_nettype none

module positional_insert_delete_list_unit
    import plv_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 func,
    input  wire logic signed [DATA_W-1:0]   value,
    input  wire logic [POS_W-1:0]           position,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [2:0]                      status,
    output logic signed [DATA_W-1:0]        entry_value,
    output logic [CNT_W-1:0]                entry_count,
    output logic                            last
);

    fifo_stat_t fifo_stat;
    logic       push;
    res_t       push_word;

    plv_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .position  (position),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_word (push_word)
    );

    plv_ofifo u_ofifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_word   (push_word),
        .stat        (fifo_stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_value (entry_value),
        .entry_count (entry_count),
        .last        (last)
    );

`ifndef SYNTH
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DATA) |-> last)
        else $error("status word without last");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DATA) |-> (entry_value == '0))
        else $error("status word with nonzero entry_value");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken without going busy");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((fifo_stat.level != 2'd2) || fifo_stat.pop))
        else $error("result pushed into full output queue");
`endif

endmodule

`default_nettype wire
